### rtl/csmv_pkg.sv
// Shared constants, item codes and types for the COO sparse mat-vec block.
// No dependencies; csmv_mac, csmv_checker and the top level refer to it by scoped names.
`default_nettype none

package csmv_pkg;

   localparam int ROWS    = 1024;
   localparam int COLS    = 1024;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 3;
   localparam int INDEX_W = 10;
   // written marks are kept as epoch tags; tag zero never matches
   localparam int EPOCH_W = 8;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int FRAC_W  = 16;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_X  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PRESET  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TERM    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ_Y  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

   typedef struct packed {
      logic capture;   // load product and base registers
      logic written;   // row was written since the last clear
   } mac_ctl_type;

endpackage

`default_nettype wire

### rtl/csmv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module csmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### rtl/csmv_mac.sv
// Multiply-accumulate for one nonzero term: registered Q32.32 product and Q16.16 base,
// then floor shift, add and saturate. Depends on csmv_pkg.
`default_nettype none

module csmv_mac (
   input  wire logic                          clock,
   input  wire csmv_pkg::mac_ctl_type         ctl,
   input  wire logic [csmv_pkg::DATA_W-1:0]   operand,
   input  wire logic [csmv_pkg::DATA_W-1:0]   x_rdata,
   input  wire logic [csmv_pkg::DATA_W-1:0]   y_rdata,
   output logic      [csmv_pkg::DATA_W-1:0]   sum
);

   localparam int SUM_W = csmv_pkg::PROD_W - csmv_pkg::FRAC_W + 1;

   logic signed [csmv_pkg::PROD_W-1:0] prod_ff;
   logic signed [csmv_pkg::PROD_W-1:0] prod_in;
   logic signed [csmv_pkg::DATA_W-1:0] base_ff;
   logic signed [csmv_pkg::DATA_W-1:0] base_in;
   logic signed [SUM_W-1:0]            total;

   assign prod_in = $signed(operand) * $signed(x_rdata);
   assign base_in = ctl.written ? $signed(y_rdata) : '0;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
      end
   end

   // arithmetic drop of the low fraction bits rounds toward minus infinity
   assign total = SUM_W'(base_ff)
                + SUM_W'($signed(prod_ff[csmv_pkg::PROD_W-1:csmv_pkg::FRAC_W]));

   always_comb begin
      if (total[SUM_W-1:csmv_pkg::DATA_W-1] == '0 ||
          total[SUM_W-1:csmv_pkg::DATA_W-1] == '1) begin
         sum = total[csmv_pkg::DATA_W-1:0];
      end else if (total[SUM_W-1]) begin
         sum = {1'b1, {(csmv_pkg::DATA_W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(csmv_pkg::DATA_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

### rtl/coo_sparse_matvec_accumulate.sv
// COO sparse matrix times vector, Q16.16, replace semantics.
// Uses csmv_pkg, csmv_ram (x, y and written-tag memories) and csmv_mac.
//
// Input channel req_*: one item per handshake (valid high, stall low).
//   func 0 loads x[col], 1 presets y[row], 2 adds value*x[col] into y[row]
//   (starting from zero on the first term of a row since the last clear),
//   3 reads y[row] back, 4 clears all written marks.
// Result channel rsp_*: one item per read, carrying row_echo and y_value.
// Steps per item: load x, preset y and clear act on accept; a read goes through
// the memory read, then the output register; a term goes through the memory read,
// multiply, then add and write back. The single read/modify/write path through the
// y memory allows one item in flight at a time.
// From accept to rsp_valid a read passes the memory read and output registers,
// the latter once it is free. The output register holds a result while rsp_stall is
// high; the next item is still taken, and a second read waits in place until the
// pending result leaves.
// Written marks are epoch tags in a memory. After reset, and on every 255th
// clear when the epoch wraps, a pass zeroes the tags of all 1024 rows;
// req_stall is high during that pass. Reset is synchronous and active high.
`default_nettype none

module coo_sparse_matvec_accumulate (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [csmv_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [csmv_pkg::INDEX_W-1:0]   req_row_index,
   input  wire logic [csmv_pkg::INDEX_W-1:0]   req_col_index,
   input  wire logic [csmv_pkg::DATA_W-1:0]    req_operand,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [csmv_pkg::INDEX_W-1:0]   rsp_row_echo,
   output logic      [csmv_pkg::DATA_W-1:0]    rsp_y_value
);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_WB   = 3'd3;
   localparam logic [2:0] ST_RDY  = 3'd4;

   localparam int ROW_W   = csmv_pkg::ROW_W;
   localparam int COL_W   = csmv_pkg::COL_W;
   localparam int DATA_W  = csmv_pkg::DATA_W;
   localparam int EPOCH_W = csmv_pkg::EPOCH_W;

   logic [2:0]                  state_ff, state_in;
   logic [ROW_W-1:0]            init_cnt_ff, init_cnt_in;
   logic [EPOCH_W-1:0]          epoch_ff, epoch_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [csmv_pkg::INDEX_W-1:0] rsp_row_ff, rsp_row_in;
   logic [DATA_W-1:0]           rsp_data_ff, rsp_data_in;
   logic [csmv_pkg::INDEX_W-1:0] row_ff, row_in;
   logic                        row_ok_ff, row_ok_in;
   logic [DATA_W-1:0]           operand_ff, operand_in;

   logic                        accept;
   logic                        row_ok, col_ok;
   logic                        is_load, is_preset, is_term, is_read, is_clear;

   logic                        x_we, x_re;
   logic [DATA_W-1:0]           x_rdata;
   logic                        y_we, y_re;
   logic [ROW_W-1:0]            y_waddr;
   logic [DATA_W-1:0]           y_wdata, y_rdata;
   logic                        tag_we, tag_re;
   logic [ROW_W-1:0]            tag_waddr;
   logic [EPOCH_W-1:0]          tag_wdata, tag_rdata;

   csmv_pkg::mac_ctl_type       mac_ctl;
   logic [DATA_W-1:0]           mac_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign row_ok = (32'(req_row_index) < csmv_pkg::ROWS);
   assign col_ok = (32'(req_col_index) < csmv_pkg::COLS);

   assign is_load   = (req_func == csmv_pkg::FUNC_LOAD_X);
   assign is_preset = (req_func == csmv_pkg::FUNC_PRESET);
   assign is_term   = (req_func == csmv_pkg::FUNC_TERM);
   assign is_read   = (req_func == csmv_pkg::FUNC_READ_Y);
   assign is_clear  = (req_func == csmv_pkg::FUNC_CLEAR);

   // x memory
   assign x_we = accept && is_load && col_ok;
   assign x_re = accept && is_term;

   // y memory: preset from the port, write back from the MAC
   assign y_we    = (accept && is_preset && row_ok) || (state_ff == ST_WB);
   assign y_waddr = (state_ff == ST_WB) ? row_ff[ROW_W-1:0] : req_row_index[ROW_W-1:0];
   assign y_wdata = (state_ff == ST_WB) ? mac_sum : req_operand;
   assign y_re    = accept && (is_term || is_read);

   // written tags: zeroing pass or mark on write back
   assign tag_we    = (state_ff == ST_INIT) || (state_ff == ST_WB);
   assign tag_waddr = (state_ff == ST_INIT) ? init_cnt_ff : row_ff[ROW_W-1:0];
   assign tag_wdata = (state_ff == ST_INIT) ? '0 : epoch_ff;
   assign tag_re    = accept && is_term;

   assign mac_ctl.capture = (state_ff == ST_MUL);
   assign mac_ctl.written = (tag_rdata == epoch_ff);

   csmv_ram #(.WIDTH(DATA_W), .DEPTH(csmv_pkg::COLS)) u_x_ram (
      .clock (clock),
      .we    (x_we),
      .waddr (req_col_index[COL_W-1:0]),
      .wdata (req_operand),
      .re    (x_re),
      .raddr (req_col_index[COL_W-1:0]),
      .rdata (x_rdata)
   );

   csmv_ram #(.WIDTH(DATA_W), .DEPTH(csmv_pkg::ROWS)) u_y_ram (
      .clock (clock),
      .we    (y_we),
      .waddr (y_waddr),
      .wdata (y_wdata),
      .re    (y_re),
      .raddr (req_row_index[ROW_W-1:0]),
      .rdata (y_rdata)
   );

   csmv_ram #(.WIDTH(EPOCH_W), .DEPTH(csmv_pkg::ROWS)) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (tag_waddr),
      .wdata (tag_wdata),
      .re    (tag_re),
      .raddr (req_row_index[ROW_W-1:0]),
      .rdata (tag_rdata)
   );

   csmv_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .operand (operand_ff),
      .x_rdata (x_rdata),
      .y_rdata (y_rdata),
      .sum     (mac_sum)
   );

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      epoch_in     = epoch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_data_in  = rsp_data_ff;
      row_in       = row_ff;
      row_ok_in    = row_ok_ff;
      operand_in   = operand_ff;

      unique case (state_ff)
         ST_INIT: begin
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == ROW_W'(csmv_pkg::ROWS - 1)) begin
               init_cnt_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               row_in     = req_row_index;
               row_ok_in  = row_ok;
               operand_in = req_operand;
               if (is_term && row_ok && col_ok) begin
                  state_in = ST_MUL;
               end else if (is_read) begin
                  state_in = ST_RDY;
               end else if (is_clear) begin
                  if (epoch_ff == '1) begin
                     // tags would alias after wrap: zero them all
                     epoch_in = EPOCH_W'(1);
                     state_in = ST_INIT;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         ST_MUL: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            state_in = ST_IDLE;
         end
         ST_RDY: begin
            // y read data holds until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_data_in  = row_ok_ff ? y_rdata : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         epoch_ff     <= EPOCH_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff  <= rsp_row_in;
      rsp_data_ff <= rsp_data_in;
      row_ff      <= row_in;
      row_ok_ff   <= row_ok_in;
      operand_ff  <= operand_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_echo = rsp_row_ff;
   assign rsp_y_value  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/csmv_checker.sv
// Port-level checks for coo_sparse_matvec_accumulate, bound to the top level.
// Depends on csmv_pkg for the item codes.
`default_nettype none

module csmv_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [csmv_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [csmv_pkg::INDEX_W-1:0]   req_row_index,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [csmv_pkg::INDEX_W-1:0]   rsp_row_echo,
   input  wire logic [csmv_pkg::DATA_W-1:0]    rsp_y_value
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_echo) && $stable(rsp_y_value))
      else $error("stalled result changed");

   // tag zeroing pass follows reset
   a_init_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item taken right after reset");

   // a read into a free output shows up with its row after the memory read and output registers
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      req_take && req_func == csmv_pkg::FUNC_READ_Y && !rsp_valid
      |=> ##1 rsp_valid && rsp_row_echo == $past(req_row_index, 2))
      else $error("read result missing or wrong row");

   // a term holds the input side through multiply and write back
   a_term_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && req_func == csmv_pkg::FUNC_TERM |=> req_stall)
      else $error("item taken during a term");

endmodule

bind coo_sparse_matvec_accumulate csmv_checker u_csmv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_func      (req_func),
   .req_row_index (req_row_index),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_row_echo  (rsp_row_echo),
   .rsp_y_value   (rsp_y_value)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for coo_sparse_matvec_accumulate: directed table, random sparse
// products and an epoch-wrap run, checked item by item against a Q16.16 predictor kept in the bench.
// Depends on csmv_pkg and the rtl of the block; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;

   localparam int FUNC_W  = csmv_pkg::FUNC_W;
   localparam int INDEX_W = csmv_pkg::INDEX_W;
   localparam int DATA_W  = csmv_pkg::DATA_W;
   localparam int ROWS    = csmv_pkg::ROWS;
   localparam int COLS    = csmv_pkg::COLS;

   localparam int CLOCK_HALF    = 4;
   localparam int RANDOM_OPS    = 300;
   localparam int WRAP_ROUNDS   = 260;    // enough clears to wrap the epoch tags
   localparam int HOLD_AT       = 40;     // result number that starts the long hold
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 32;
   localparam int LIMIT_CYCLES  = 400000;

   localparam logic [FUNC_W-1:0] FUNC_RSVD_LO  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_RSVD_MID = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_RSVD_HI  = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic [DATA_W-1:0]  operand;
   } matvec_op_type;

   typedef struct packed {
      matvec_op_type      op;
      logic               typed;   // y_ref holds the expected read value
      logic [DATA_W-1:0]  y_ref;
   } directed_row_type;

   typedef struct packed {
      logic [INDEX_W-1:0] row;
      logic [DATA_W-1:0]  y;
   } y_read_type;

   localparam int DIRECTED_ROWS = 25;
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{'{csmv_pkg::FUNC_LOAD_X, 10'd0,    10'd0,    32'h7fff_ffff}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_LOAD_X, 10'd0,    10'd1023, 32'h8000_0000}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_LOAD_X, 10'd1023, 10'd5,    32'h0001_0000}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_PRESET, 10'd0,    10'd1023, 32'h1234_5678}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_READ_Y, 10'd0,    10'd0,    32'h0},         1'b1, 32'h1234_5678},
      '{'{csmv_pkg::FUNC_PRESET, 10'd1023, 10'd0,    32'h8000_0000}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_READ_Y, 10'd1023, 10'd1023, 32'hffff_ffff}, 1'b1, 32'h8000_0000},
      // first term after reset starts from zero, not from the preset
      '{'{csmv_pkg::FUNC_TERM,   10'd0,    10'd5,    32'h0002_0000}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_TERM,   10'd0,    10'd5,    32'h0003_0000}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_READ_Y, 10'd0,    10'd0,    32'h0},         1'b1, 32'h0005_0000},
      '{'{csmv_pkg::FUNC_CLEAR,  10'd0,    10'd0,    32'h0},         1'b0, 32'h0},
      // -2^-16 times 1.0 after the clear starts row 0 from zero again
      '{'{csmv_pkg::FUNC_TERM,   10'd0,    10'd5,    32'hffff_ffff}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_READ_Y, 10'd0,    10'd0,    32'h0},         1'b1, 32'hffff_ffff},
      // huge products: sum saturates high, then low
      '{'{csmv_pkg::FUNC_TERM,   10'd1023, 10'd0,    32'h7fff_ffff}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_TERM,   10'd1023, 10'd1023, 32'h7fff_ffff}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_READ_Y, 10'd1023, 10'd0,    32'h0},         1'b1, 32'h8000_0000},
      '{'{FUNC_RSVD_LO,          10'd0,    10'd5,    32'h1234_0000}, 1'b0, 32'h0},
      '{'{FUNC_RSVD_MID,         10'd1023, 10'd0,    32'hffff_ffff}, 1'b0, 32'h0},
      '{'{FUNC_RSVD_HI,          10'd0,    10'd5,    32'h7fff_ffff}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_READ_Y, 10'd0,    10'd0,    32'h0},         1'b1, 32'hffff_ffff},
      // untouched row keeps its preset across a clear
      '{'{csmv_pkg::FUNC_PRESET, 10'd2,    10'd0,    32'h0000_0007}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_CLEAR,  10'd1023, 10'd1023, 32'hffff_ffff}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_READ_Y, 10'd2,    10'd0,    32'h0},         1'b1, 32'h0000_0007},
      '{'{csmv_pkg::FUNC_TERM,   10'd1023, 10'd1023, 32'h8000_0000}, 1'b0, 32'h0},
      '{'{csmv_pkg::FUNC_READ_Y, 10'd1023, 10'd0,    32'h0},         1'b1, 32'h7fff_ffff}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func;
   logic [INDEX_W-1:0]  req_row_index;
   logic [INDEX_W-1:0]  req_col_index;
   logic [DATA_W-1:0]   req_operand;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [INDEX_W-1:0]  rsp_row_echo;
   logic [DATA_W-1:0]   rsp_y_value;

   // predictor state
   logic signed [DATA_W-1:0] x_vec [COLS];
   logic signed [DATA_W-1:0] y_vec [ROWS];
   bit                       y_row_dirty [ROWS];
   y_read_type               y_reads_due [$];

   // stimulus bookkeeping: which entries hold a defined value
   bit                  x_loaded [COLS];
   bit                  y_defined [ROWS];
   logic [INDEX_W-1:0]  x_cols [$];
   logic [INDEX_W-1:0]  y_rows [$];

   int  fail_count = 0;
   int  ops_accepted = 0;
   bit  sender_busy = 1'b1;
   bit  rsp_busy = 1'b1;

   coo_sparse_matvec_accumulate dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_operand   (req_operand),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_row_echo  (rsp_row_echo),
      .rsp_y_value   (rsp_y_value)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic matvec_op_type op_of(input logic [FUNC_W-1:0] func,
                                           input logic [INDEX_W-1:0] row,
                                           input logic [INDEX_W-1:0] col,
                                           input logic [DATA_W-1:0] operand);
      op_of = '{func, row, col, operand};
   endfunction

   // Q16.16 value: mostly small magnitudes, plus extremes and full-range noise
   function automatic logic [DATA_W-1:0] rand_fixed();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         4: return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0000_0000;
         default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      endcase
   endfunction

   // Applies one item to the predictor; returns 1 with the read value for a read.
   function automatic bit apply_matvec_op(input matvec_op_type op,
                                          output logic [DATA_W-1:0] y_out);
      logic signed [63:0] a64;
      logic signed [63:0] b64;
      logic signed [63:0] sum;
      y_out = '0;
      apply_matvec_op = 1'b0;
      case (op.func)
         csmv_pkg::FUNC_LOAD_X: x_vec[op.col] = op.operand;
         csmv_pkg::FUNC_PRESET: y_vec[op.row] = op.operand;
         csmv_pkg::FUNC_TERM: begin
            a64 = $signed(op.operand);
            b64 = x_vec[op.col];
            // arithmetic shift of the Q32.32 product floors to Q16.16
            sum = (a64 * b64) >>> 16;
            if (y_row_dirty[op.row])
               sum = sum + 64'(y_vec[op.row]);
            if (sum > 64'sd2147483647)
               y_vec[op.row] = 32'h7fff_ffff;
            else if (sum < -64'sd2147483648)
               y_vec[op.row] = 32'h8000_0000;
            else
               y_vec[op.row] = sum[DATA_W-1:0];
            y_row_dirty[op.row] = 1'b1;
         end
         csmv_pkg::FUNC_READ_Y: begin
            y_out = y_vec[op.row];
            apply_matvec_op = 1'b1;
         end
         csmv_pkg::FUNC_CLEAR: foreach (y_row_dirty[i]) y_row_dirty[i] = 1'b0;
         default: ;
      endcase
   endfunction

   // Offers one item after a random gap and waits for it to be taken.
   task automatic send_op(input matvec_op_type op, input logic typed,
                          input logic [DATA_W-1:0] y_ref);
      int gap;
      logic [DATA_W-1:0] y_pred;
      if ($urandom_range(0, 39) == 0)
         sender_busy = !sender_busy;
      gap = sender_busy ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      repeat (gap) begin
         // payload wanders while valid is low
         req_valid     <= 1'b0;
         req_func      <= FUNC_W'($urandom);
         req_row_index <= INDEX_W'($urandom);
         req_col_index <= INDEX_W'($urandom);
         req_operand   <= $urandom;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= op.func;
      req_row_index <= op.row;
      req_col_index <= op.col;
      req_operand   <= op.operand;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (apply_matvec_op(op, y_pred))
         y_reads_due.push_back('{op.row, typed ? y_ref : y_pred});
      if (op.func == csmv_pkg::FUNC_LOAD_X && !x_loaded[op.col]) begin
         x_loaded[op.col] = 1'b1;
         x_cols.push_back(op.col);
      end
      if ((op.func == csmv_pkg::FUNC_PRESET || op.func == csmv_pkg::FUNC_TERM) &&
          !y_defined[op.row]) begin
         y_defined[op.row] = 1'b1;
         y_rows.push_back(op.row);
      end
      if (op.func <= csmv_pkg::FUNC_CLEAR)
         ops_accepted++;
   endtask

   // result side: random stalls, one long hold, field-by-field compare
   initial begin : rsp_side
      int stall_left;
      int results_seen;
      y_read_type want;
      stall_left = 0;
      results_seen = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0)
            stall_left--;
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (y_reads_due.size() == 0) begin
               $error("unexpected result: row_echo %0d y_value %h", rsp_row_echo, rsp_y_value);
               fail_count++;
            end else begin
               want = y_reads_due.pop_front();
               if (rsp_row_echo !== want.row) begin
                  $error("row_echo: expected %0d, got %0d", want.row, rsp_row_echo);
                  fail_count++;
               end
               if (rsp_y_value !== want.y) begin
                  $error("y_value: expected %h, got %h", want.y, rsp_y_value);
                  fail_count++;
               end
            end
            if (results_seen == HOLD_AT) begin
               stall_left = HOLD_CYCLES;
            end else begin
               if ($urandom_range(0, 29) == 0)
                  rsp_busy = !rsp_busy;
               stall_left = rsp_busy ? $urandom_range(0, 11) : 0;
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("coo_sparse_matvec_accumulate verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [INDEX_W-1:0] work_rows [4];
      logic [INDEX_W-1:0] r;
      int j;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = csmv_pkg::FUNC_LOAD_X;
      req_row_index = '0;
      req_col_index = '0;
      req_operand   = '0;
      foreach (y_row_dirty[i]) y_row_dirty[i] = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_op(DIRECTED_TABLE[i].op, DIRECTED_TABLE[i].typed, DIRECTED_TABLE[i].y_ref);

      // random products: refresh some x and y, usually clear, a burst of terms, reads, now and then a reserved code
      while (ops_accepted < DIRECTED_ROWS + RANDOM_OPS) begin
         repeat ((x_cols.size() < 8) ? 4 : $urandom_range(0, 3))
            send_op(op_of(csmv_pkg::FUNC_LOAD_X, INDEX_W'($urandom), INDEX_W'($urandom),
                          rand_fixed()), 1'b0, '0);
         repeat ($urandom_range(0, 2))
            send_op(op_of(csmv_pkg::FUNC_PRESET, INDEX_W'($urandom), INDEX_W'($urandom),
                          rand_fixed()), 1'b0, '0);
         if ($urandom_range(0, 7) != 0)
            send_op(op_of(csmv_pkg::FUNC_CLEAR, INDEX_W'($urandom), INDEX_W'($urandom),
                          $urandom), 1'b0, '0);
         foreach (work_rows[i])
            work_rows[i] = ($urandom_range(0, 1) != 0) ?
                           y_rows[$urandom_range(0, y_rows.size() - 1)] : INDEX_W'($urandom);
         repeat ($urandom_range(1, 8))
            send_op(op_of(csmv_pkg::FUNC_TERM, work_rows[$urandom_range(0, 3)],
                          x_cols[$urandom_range(0, x_cols.size() - 1)], rand_fixed()),
                    1'b0, '0);
         repeat ($urandom_range(0, 3)) begin
            r = work_rows[$urandom_range(0, 3)];
            if (!y_defined[r] || $urandom_range(0, 3) == 0)
               r = y_rows[$urandom_range(0, y_rows.size() - 1)];
            send_op(op_of(csmv_pkg::FUNC_READ_Y, r, INDEX_W'($urandom), $urandom), 1'b0, '0);
         end
         if ($urandom_range(0, 5) == 0)
            send_op(op_of(FUNC_W'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI)),
                          INDEX_W'($urandom), INDEX_W'($urandom), $urandom), 1'b0, '0);
      end

      // many short products so the written-mark epoch wraps and gets scrubbed
      repeat (WRAP_ROUNDS) begin
         r = INDEX_W'($urandom_range(0, 15));
         send_op(op_of(csmv_pkg::FUNC_CLEAR, INDEX_W'($urandom), INDEX_W'($urandom),
                       $urandom), 1'b0, '0);
         j = $urandom_range(1, 2);
         repeat (j)
            send_op(op_of(csmv_pkg::FUNC_TERM, r, x_cols[$urandom_range(0, x_cols.size() - 1)],
                          rand_fixed()), 1'b0, '0);
         if ($urandom_range(0, 2) == 0)
            send_op(op_of(csmv_pkg::FUNC_READ_Y, r, INDEX_W'($urandom), $urandom), 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (y_reads_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("coo_sparse_matvec_accumulate verification clean");
      else
         $display("coo_sparse_matvec_accumulate verification failed");
      $finish;
   end

endmodule
